FILE: hdl/leg_inverse_kinematics_core_macros.svh
// Assertion helpers for the RTL file that carries checks.
`ifndef LEG_INVERSE_KINEMATICS_CORE_MACROS_SVH
`define LEG_INVERSE_KINEMATICS_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define LIK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define LIK_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lik_pkg.sv
`default_nettype none
package lik_pkg;

    // Servo position width; the payload types below are built on it.
    localparam int POSITION_BITS = 12;

    // CORDIC datapath widths: vector lanes and angle accumulator.
    localparam int CW = 28;
    localparam int ACC_W = 34;
    localparam int ATAN_LEN = 24;

    // atan(2^-i) in units of 2^32 per full turn.
    localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Configuration register indexes.
    localparam logic [1:0] REG_COXA   = 2'd0;
    localparam logic [1:0] REG_FEMUR  = 2'd1;
    localparam logic [1:0] REG_BASE   = 2'd2;
    localparam logic [1:0] REG_MARGIN = 2'd3;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] target_z;
        logic               mirror_side;
    } t_ik_in;

    typedef struct packed {
        logic [POSITION_BITS-1:0] upper_position;
        logic [POSITION_BITS-1:0] lower_position;
        logic                     reachable;
    } t_ik_out;

endpackage
`default_nettype wire

FILE: hdl/lik_sqrt_cell.sv
`default_nettype none
// One bit of a restoring integer square root; decides root bit BIT_POS.
module lik_sqrt_cell #(
    parameter int BIT_POS = 15,
    parameter int SB_W = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [31:0]     i_rem,
    input  wire logic [15:0]     i_root,
    input  wire logic [SB_W-1:0] i_sb,
    output logic                 o_valid,
    output logic [31:0]          o_rem,
    output logic [15:0]          o_root,
    output logic [SB_W-1:0]      o_sb
);
    logic [33:0] trial;
    logic [33:0] rem_ext;
    logic        take;

    assign trial   = (34'(i_root) << (BIT_POS + 1)) + (34'd1 << (2 * BIT_POS));
    assign rem_ext = 34'(i_rem);
    assign take    = rem_ext >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sb <= i_sb;
            if (take) begin
                o_rem  <= 32'(rem_ext - trial);
                o_root <= i_root | (16'd1 << BIT_POS);
            end else begin
                o_rem  <= i_rem;
                o_root <= i_root;
            end
        end
    end
endmodule
`default_nettype wire

FILE: hdl/lik_cordic_cell.sv
`default_nettype none
// One vectoring CORDIC micro-rotation, drives y toward zero.
module lik_cordic_cell #(
    parameter int STEP = 0,
    parameter int SB_W = 1
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire logic signed [lik_pkg::CW-1:0]    i_x,
    input  wire logic signed [lik_pkg::CW-1:0]    i_y,
    input  wire logic signed [lik_pkg::ACC_W-1:0] i_acc,
    input  wire logic [SB_W-1:0]                 i_sb,
    output logic                                 o_valid,
    output logic signed [lik_pkg::CW-1:0]         o_x,
    output logic signed [lik_pkg::CW-1:0]         o_y,
    output logic signed [lik_pkg::ACC_W-1:0]      o_acc,
    output logic [SB_W-1:0]                      o_sb
);
    import lik_pkg::*;

    logic signed [ACC_W-1:0] angle;
    logic signed [CW-1:0]    x_sh;
    logic signed [CW-1:0]    y_sh;

    assign angle = signed'({{(ACC_W-32){1'b0}}, ATAN_TURNS[STEP]});
    assign x_sh  = i_x >>> STEP;
    assign y_sh  = i_y >>> STEP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sb <= i_sb;
            if (i_y > 0) begin
                o_x   <= i_x + y_sh;
                o_y   <= i_y - x_sh;
                o_acc <= i_acc + angle;
            end else begin
                o_x   <= i_x - y_sh;
                o_y   <= i_y + x_sh;
                o_acc <= i_acc - angle;
            end
        end
    end
endmodule
`default_nettype wire

FILE: hdl/lik_pos_map.sv
`default_nettype none
// Turns an angle (2^32 per turn) into a clamped servo position in two stages.
module lik_pos_map (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire logic signed [lik_pkg::ACC_W-1:0] i_acc,
    output logic                                 o_valid,
    output logic [lik_pkg::POSITION_BITS-1:0]    o_pos,
    output logic                                 o_clamped
);
    import lik_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam int MAG_W = ACC_W - 1;
    localparam int PROD_W = MAG_W + PB;
    localparam logic [PB-1:0] TOP = {PB{1'b1}};
    localparam logic signed [PB+2:0] CENTER = (PB+3)'(1) <<< (PB - 1);
    localparam logic signed [PB+2:0] TOP_S = signed'({3'b000, TOP});

    logic [ACC_W-1:0]    neg_acc;
    logic [MAG_W-1:0]    mag;
    logic                r_neg;
    logic [PROD_W-1:0]   r_prod;
    logic                r_valid;
    logic [PROD_W:0]     rounded;
    logic [PB+1:0]       q;
    logic signed [PB+2:0] p;

    assign neg_acc = ACC_W'(-i_acc);
    assign mag = i_acc[ACC_W-1] ? neg_acc[MAG_W-1:0] : i_acc[MAG_W-1:0];

    // Round half away from zero: magnitude first, sign applied afterwards.
    assign rounded = (PROD_W+1)'(r_prod) + ((PROD_W+1)'(1) << 31);
    assign q = rounded[PB+33:32];
    assign p = r_neg ? CENTER - signed'({1'b0, q}) : CENTER + signed'({1'b0, q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            o_valid <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg  <= i_acc[ACC_W-1];
            r_prod <= PROD_W'(mag) * PROD_W'(TOP);
            if (p < 0) begin
                o_pos     <= '0;
                o_clamped <= 1'b1;
            end else if (p > TOP_S) begin
                o_pos     <= TOP;
                o_clamped <= 1'b1;
            end else begin
                o_pos     <= p[PB-1:0];
                o_clamped <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: hdl/leg_inverse_kinematics_core.sv
// Throughput: one item per cycle while the skid entry is empty; every stage is
// a register cell in one chain. A two-entry output buffer lets the chain keep
// moving while a result waits. Reset (synchronous, active low) empties the
// chain and the output buffer and loads the registers with their defaults:
// coxa 1331, femur 2048, base 1882, margin 13.
`default_nettype none
module leg_inverse_kinematics_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire lik_pkg::t_ik_in i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output lik_pkg::t_ik_out     o_out_data,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [3:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import lik_pkg::*;

    `include "leg_inverse_kinematics_core_macros.svh"

    localparam int SQ_SB_W = 49;

    typedef struct packed {
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ACC_W-1:0] acc;
        logic                    zero;
    } t_cvec;

    // Quarter-turn pre-rotation puts the vector in the right half plane, then
    // scales it by 256 for the CORDIC lanes. A zero vector is flagged so that
    // its angle can be forced to zero at the end of the chain.
    function automatic t_cvec prerot(input logic signed [17:0] px,
                                     input logic signed [17:0] py);
        t_cvec             v;
        logic signed [17:0] rx;
        logic signed [17:0] ry;
        rx = px;
        ry = py;
        v.acc = '0;
        if (px < 0) begin
            if (py >= 0) begin
                rx = py;
                ry = -px;
                v.acc = (ACC_W)'(1) <<< 30;
            end else begin
                rx = -py;
                ry = px;
                v.acc = -((ACC_W)'(1) <<< 30);
            end
        end
        v.x = {{(CW-26){rx[17]}}, rx, 8'b0};
        v.y = {{(CW-26){ry[17]}}, ry, 8'b0};
        v.zero = (px == 0) && (py == 0);
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers on the APB port. Writes land when the access
    // phase completes; reads are combinational from the same registers.
    // ------------------------------------------------------------------
    logic [14:0] r_coxa;
    logic [14:0] r_femur;
    logic [14:0] r_base;
    logic [7:0]  r_margin;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coxa   <= 15'd1331;
            r_femur  <= 15'd2048;
            r_base   <= 15'd1882;
            r_margin <= 8'd13;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_COXA:   r_coxa   <= pwdata[14:0];
                REG_FEMUR:  r_femur  <= pwdata[14:0];
                REG_BASE:   r_base   <= pwdata[14:0];
                REG_MARGIN: r_margin <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_COXA:   prdata = {17'b0, r_coxa};
            REG_FEMUR:  prdata = {17'b0, r_femur};
            REG_BASE:   prdata = {17'b0, r_base};
            REG_MARGIN: prdata = {24'b0, r_margin};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Chain enable. The whole chain moves as one; it only halts when both
    // the output register and the skid entry hold results.
    // ------------------------------------------------------------------
    logic    en;
    logic    r_out_valid;
    logic    r_skid_valid;
    t_ik_out r_out_data;
    t_ik_out r_skid_data;

    assign en = !r_skid_valid;
    assign o_in_ready = en;

    // Stage 0: capture the item.
    logic               r_v0;
    logic signed [15:0] r_x0;
    logic signed [15:0] r_y0;
    logic signed [15:0] r_z0;
    logic               r_m0;

    // Stage 1: squares of x and y.
    logic               r_v1;
    logic [31:0]        r_xx1;
    logic [31:0]        r_yy1;
    logic [SQ_SB_W-1:0] r_sb1;

    // Stage 2: sum of squares, the radicand.
    logic               r_v2;
    logic [31:0]        r_n2;
    logic [SQ_SB_W-1:0] r_sb2;

    logic signed [31:0] xx_full;
    logic signed [31:0] yy_full;

    assign xx_full = 32'(r_x0) * 32'(r_x0);
    assign yy_full = 32'(r_y0) * 32'(r_y0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_in_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0  <= i_in_data.target_x;
            r_y0  <= i_in_data.target_y;
            r_z0  <= i_in_data.target_z;
            r_m0  <= i_in_data.mirror_side;
            r_xx1 <= unsigned'(xx_full);
            r_yy1 <= unsigned'(yy_full);
            r_sb1 <= {r_x0, r_y0, r_z0, r_m0};
            r_n2  <= r_xx1 + r_yy1;
            r_sb2 <= r_sb1;
        end
    end

    // ------------------------------------------------------------------
    // Square root: sixteen cells, one root bit each, most significant first.
    // The target coordinates ride along as sideband.
    // ------------------------------------------------------------------
    logic               sq_v   [0:16];
    logic [31:0]        sq_rem [0:16];
    logic [15:0]        sq_root[0:16];
    logic [SQ_SB_W-1:0] sq_sb  [0:16];

    assign sq_v[0]    = r_v2;
    assign sq_rem[0]  = r_n2;
    assign sq_root[0] = '0;
    assign sq_sb[0]   = r_sb2;

    for (genvar k = 0; k < 16; k++) begin : g_sqrt
        lik_sqrt_cell #(
            .BIT_POS(15 - k),
            .SB_W   (SQ_SB_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(sq_v[k]),
            .i_rem  (sq_rem[k]),
            .i_root (sq_root[k]),
            .i_sb   (sq_sb[k]),
            .o_valid(sq_v[k+1]),
            .o_rem  (sq_rem[k+1]),
            .o_root (sq_root[k+1]),
            .o_sb   (sq_sb[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage D: offsets from the shoulder joint.
    // Stage M: squared distances, squared reach limit and the pre-rotated
    // vectors for both angle lanes.
    // ------------------------------------------------------------------
    logic               r_vd;
    logic signed [17:0] r_dx;
    logic signed [17:0] r_zrel;
    logic signed [15:0] r_xd;
    logic signed [15:0] r_yd;
    logic               r_md;

    logic signed [15:0] sb_x;
    logic signed [15:0] sb_y;
    logic signed [15:0] sb_z;
    logic               sb_m;

    assign {sb_x, sb_y, sb_z, sb_m} = sq_sb[16];

    logic               r_vm;
    logic [31:0]        r_dxsq;
    logic [31:0]        r_zsq;
    logic [31:0]        r_limsq;
    t_cvec              r_up;
    t_cvec              r_lo;

    logic signed [35:0] dxsq_full;
    logic signed [35:0] zsq_full;
    logic [15:0]        lim;
    logic signed [17:0] lo_x;
    logic signed [17:0] lo_y;

    assign dxsq_full = 36'(r_dx) * 36'(r_dx);
    assign zsq_full  = 36'(r_zrel) * 36'(r_zrel);
    assign lim       = 16'(r_femur) + 16'(r_margin);
    assign lo_x      = r_md ? -18'(r_xd) : 18'(r_xd);
    assign lo_y      = r_md ? -18'(r_yd) : 18'(r_yd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
            r_vm <= 1'b0;
        end else if (en) begin
            r_vd <= sq_v[16];
            r_vm <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx    <= signed'({2'b00, sq_root[16]}) - signed'({3'b000, r_coxa});
            r_zrel  <= 18'(sb_z) - signed'({3'b000, r_base});
            r_xd    <= sb_x;
            r_yd    <= sb_y;
            r_md    <= sb_m;
            r_dxsq  <= unsigned'(dxsq_full[31:0]);
            r_zsq   <= unsigned'(zsq_full[31:0]);
            r_limsq <= 32'(lim) * 32'(lim);
            r_up    <= prerot(r_dx, r_zrel);
            r_lo    <= prerot(lo_x, lo_y);
        end
    end

    // Reach test, strictly greater than the limit squared is out of reach.
    logic        reach_m;

    assign reach_m = (33'(r_dxsq) + 33'(r_zsq)) <= 33'(r_limsq);

    // ------------------------------------------------------------------
    // Two CORDIC lanes of CORDIC_STEPS cells each. The upper lane carries the
    // reach flag and its zero flag; the lower lane carries its zero flag.
    // ------------------------------------------------------------------
    logic                    cu_v  [0:CORDIC_STEPS];
    logic signed [CW-1:0]    cu_x  [0:CORDIC_STEPS];
    logic signed [CW-1:0]    cu_y  [0:CORDIC_STEPS];
    logic signed [ACC_W-1:0] cu_acc[0:CORDIC_STEPS];
    logic [1:0]              cu_sb [0:CORDIC_STEPS];

    logic                    cl_v  [0:CORDIC_STEPS];
    logic signed [CW-1:0]    cl_x  [0:CORDIC_STEPS];
    logic signed [CW-1:0]    cl_y  [0:CORDIC_STEPS];
    logic signed [ACC_W-1:0] cl_acc[0:CORDIC_STEPS];
    logic [0:0]              cl_sb [0:CORDIC_STEPS];

    assign cu_v[0]   = r_vm;
    assign cu_x[0]   = r_up.x;
    assign cu_y[0]   = r_up.y;
    assign cu_acc[0] = r_up.acc;
    assign cu_sb[0]  = {reach_m, r_up.zero};

    assign cl_v[0]   = r_vm;
    assign cl_x[0]   = r_lo.x;
    assign cl_y[0]   = r_lo.y;
    assign cl_acc[0] = r_lo.acc;
    assign cl_sb[0]  = r_lo.zero;

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
        lik_cordic_cell #(
            .STEP(s),
            .SB_W(2)
        ) u_upper (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(cu_v[s]),
            .i_x    (cu_x[s]),
            .i_y    (cu_y[s]),
            .i_acc  (cu_acc[s]),
            .i_sb   (cu_sb[s]),
            .o_valid(cu_v[s+1]),
            .o_x    (cu_x[s+1]),
            .o_y    (cu_y[s+1]),
            .o_acc  (cu_acc[s+1]),
            .o_sb   (cu_sb[s+1])
        );

        lik_cordic_cell #(
            .STEP(s),
            .SB_W(1)
        ) u_lower (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(cl_v[s]),
            .i_x    (cl_x[s]),
            .i_y    (cl_y[s]),
            .i_acc  (cl_acc[s]),
            .i_sb   (cl_sb[s]),
            .o_valid(cl_v[s+1]),
            .o_x    (cl_x[s+1]),
            .o_y    (cl_y[s+1]),
            .o_acc  (cl_acc[s+1]),
            .o_sb   (cl_sb[s+1])
        );
    end

    // The residual x and y of the last cell are not needed; only the
    // accumulated angle goes on. A zero vector has angle zero.
    logic signed [ACC_W-1:0] ang_up;
    logic signed [ACC_W-1:0] ang_lo;

    assign ang_up = cu_sb[CORDIC_STEPS][0] ? '0 : cu_acc[CORDIC_STEPS];
    assign ang_lo = cl_sb[CORDIC_STEPS][0] ? '0 : cl_acc[CORDIC_STEPS];

    // ------------------------------------------------------------------
    // Position mapping, two stages per lane; the reach flag follows along.
    // ------------------------------------------------------------------
    logic                     pu_v;
    logic                     pl_v;
    logic [POSITION_BITS-1:0] pu_pos;
    logic [POSITION_BITS-1:0] pl_pos;
    logic                     pu_clamp;
    logic                     pl_clamp;
    logic                     r_reach_p1;
    logic                     r_reach_p2;

    lik_pos_map u_map_upper (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (cu_v[CORDIC_STEPS]),
        .i_acc    (ang_up),
        .o_valid  (pu_v),
        .o_pos    (pu_pos),
        .o_clamped(pu_clamp)
    );

    lik_pos_map u_map_lower (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (cl_v[CORDIC_STEPS]),
        .i_acc    (ang_lo),
        .o_valid  (pl_v),
        .o_pos    (pl_pos),
        .o_clamped(pl_clamp)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_reach_p1 <= cu_sb[CORDIC_STEPS][1];
            r_reach_p2 <= r_reach_p1;
        end
    end

    logic    last_valid;
    t_ik_out last_data;

    assign last_valid = pu_v && pl_v;
    assign last_data.upper_position = pu_pos;
    assign last_data.lower_position = pl_pos;
    assign last_data.reachable      = r_reach_p2 && !pu_clamp && !pl_clamp;

    // ------------------------------------------------------------------
    // Output register with one skid entry. A result arriving while the
    // output is held goes to the skid entry; that halts the chain until the
    // skid entry drains into the output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= last_valid;
                r_out_data  <= last_data;
            end
        end else if (last_valid && en) begin
            r_skid_valid <= 1'b1;
            r_skid_data  <= last_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The skid entry is only ever occupied behind a held output result.
    `LIK_ASSERT_IMP(a_skid_behind_out, r_skid_valid, r_out_valid, "skid entry without output")
    // The skid entry fills only from a cycle in which the output was stalled.
    `LIK_ASSERT_IMP(a_skid_fill_on_stall, $rose(r_skid_valid), $past(r_out_valid && !i_out_ready),
        "skid entry filled without a stall")
    // A full skid entry blocks new items at the input.
    `LIK_ASSERT_IMP(a_no_accept_when_full, r_skid_valid, !o_in_ready, "input open while chain halted")

endmodule
`default_nettype wire

FILE: tb/sv/leg_ik_checker.sv
`default_nettype none
module leg_ik_checker (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_ready,
    input  wire lik_pkg::t_ik_in  i_in_data,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_ready,
    input  wire lik_pkg::t_ik_out i_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [31:0]      i_cfg_val,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import lik_pkg::*;

    localparam int STEPS = 16;

    longint coxa, femur, base_h, margin;
    t_ik_out expected_results[$];

    function automatic longint shift_right(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint floor_sqrt(longint n);
        longint res;
        longint bitv;
        res = 0;
        bitv = 64'sh4000_0000_0000_0000;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC, angle in 2^32 units per full turn.
    function automatic longint angle_of(longint y, longint x);
        longint acc, t, nx, ny;
        acc = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; acc = 64'sd1 << 30;
            end else begin
                t = x; x = -y; y = t; acc = -(64'sd1 << 30);
            end
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < STEPS; i++) begin
            if (y > 0) begin
                nx = x + shift_right(y, i);
                ny = y - shift_right(x, i);
                acc = acc + longint'(ATAN_TURNS[i]);
            end else begin
                nx = x - shift_right(y, i);
                ny = y + shift_right(x, i);
                acc = acc - longint'(ATAN_TURNS[i]);
            end
            x = nx;
            y = ny;
        end
        return acc;
    endfunction

    function automatic longint servo_position(longint a, inout bit clamped);
        longint top, mag, q, p;
        top = (64'sd1 << POSITION_BITS) - 1;
        mag = (a < 0) ? -a : a;
        q = (mag * top + (64'sd1 << 31)) >>> 32;
        p = (64'sd1 << (POSITION_BITS - 1)) + ((a < 0) ? -q : q);
        if (p < 0) begin p = 0; clamped = 1; end
        if (p > top) begin p = top; clamped = 1; end
        return p;
    endfunction

    function automatic t_ik_out solve_leg(t_ik_in t);
        longint x, y, z, r, dx, zr, dist_sq, lim;
        bit clamped;
        t_ik_out o;
        x = t.target_x;
        y = t.target_y;
        z = t.target_z;
        clamped = 0;
        r = floor_sqrt(x * x + y * y);
        dx = r - coxa;
        zr = z - base_h;
        dist_sq = dx * dx + zr * zr;
        lim = femur + margin;
        o.upper_position = POSITION_BITS'(servo_position(angle_of(zr, dx), clamped));
        o.lower_position = t.mirror_side
                         ? POSITION_BITS'(servo_position(angle_of(-y, -x), clamped))
                         : POSITION_BITS'(servo_position(angle_of(y, x), clamped));
        o.reachable = (dist_sq <= lim * lim) && !clamped;
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 o_result_count, what, got, want);
        o_fail_count++;
    endtask

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_ik_out want;
        if (!i_rst_n) begin
            coxa <= 1331; femur <= 2048; base_h <= 1882; margin <= 13;
            expected_results.delete();
            o_fail_count <= 0;
            o_result_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_COXA:   coxa <= i_cfg_val[14:0];
                    REG_FEMUR:  femur <= i_cfg_val[14:0];
                    REG_BASE:   base_h <= i_cfg_val[14:0];
                    REG_MARGIN: margin <= i_cfg_val[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) expected_results.push_back(solve_leg(i_in_data));
            if (i_out_valid && i_out_ready) begin
                o_result_count <= o_result_count + 1;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result count", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.upper_position !== want.upper_position)
                        report_mismatch("upper_position", i_out_data.upper_position,
                                        want.upper_position);
                    if (i_out_data.lower_position !== want.lower_position)
                        report_mismatch("lower_position", i_out_data.lower_position,
                                        want.lower_position);
                    if (i_out_data.reachable !== want.reachable)
                        report_mismatch("reachable", i_out_data.reachable, want.reachable);
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: tb/sv/leg_inverse_kinematics_core_test.sv
`default_nettype none
module leg_inverse_kinematics_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lik_pkg::*;

    // The drain wait lets the chain settle after the last expected result.
    localparam int DRAIN_CYCLES = 100;
    localparam longint CYCLE_LIMIT = 400000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    t_ik_in      in_data = '0;
    logic        out_valid;
    logic        out_ready = 0;
    t_ik_out     out_data;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending, result_count;

    // Idle odds in percent for each side; changed by the stimulus phases.
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_receiver = 0;
    int          items_sent = 0;
    longint      cycle_count = 0;

    always #10 i_clk = ~i_clk;

    leg_inverse_kinematics_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    leg_ik_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_we(psel && penable && pwrite && pready),
        .i_cfg_idx(paddr[3:2]), .i_cfg_val(pwdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // The receiver decides its ready every cycle; a hold request forces it low.
    always @(posedge i_clk) begin
        if (hold_receiver) out_ready <= 0;
        else out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // One register write: a setup phase, then the access phase.
    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Offer one item and keep it steady until the block takes it. Valid stays
    // high after the item is taken so that the next item can follow directly;
    // idle cycles and the drain wait lower it.
    task automatic send_item(t_ik_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge i_clk);
        end
        in_valid <= 1;
        in_data <= item;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_point(int x, int y, int z, bit m);
        t_ik_in item;
        item.target_x = 16'(x);
        item.target_y = 16'(y);
        item.target_z = 16'(z);
        item.mirror_side = m;
        send_item(item);
    endtask

    // Wait until every expected result has come, then let the chain settle.
    task automatic drain_block();
        in_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random points: most land near the leg's working range so that the
    // reachable flag toggles; the rest cover the full signed field.
    task automatic random_points(int count);
        t_ik_in item;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(3) == 0) begin
                item.target_x = 16'($urandom);
                item.target_y = 16'($urandom);
                item.target_z = 16'($urandom);
                item.mirror_side = 1'($urandom);
            end else begin
                item.target_x = 16'($signed($urandom_range(8000)) - 4000);
                item.target_y = 16'($signed($urandom_range(8000)) - 4000);
                item.target_z = 16'($signed($urandom_range(8000)) - 2000);
                item.mirror_side = 1'($urandom_range(1));
            end
            send_item(item);
        end
    endtask

    task automatic configure(int c, int f, int b, int m);
        write_register(REG_COXA, c);
        write_register(REG_FEMUR, f);
        write_register(REG_BASE, b);
        write_register(REG_MARGIN, m);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed points at reset settings: zero vector, the negative x axis,
        // field extremes, each mirror setting and the reach boundary.
        send_point(0, 0, 0, 0);
        send_point(0, 0, 0, 1);
        send_point(-256, 0, 1882, 0);
        send_point(256, 0, 1882, 1);
        send_point(-32768, -32768, -32768, 0);
        send_point(32767, 32767, 32767, 1);
        send_point(-32768, 32767, 0, 1);
        send_point(32767, -32768, -1, 0);
        send_point(3379, 0, 1882, 0);
        send_point(3392, 0, 1882, 0);
        send_point(3393, 0, 1882, 1);
        send_point(1331, 0, 1882, 0);
        send_point(0, -1, 0, 0);
        send_point(-1, 0, 0, 1);
        send_point(2000, 1500, -500, 0);
        send_point(-2000, -1500, 3000, 1);
        drain_block();

        // Registers at their extremes, directed and random points under each.
        configure(0, 0, 0, 0);
        send_point(0, 0, 0, 0);
        send_point(1, 0, 0, 0);
        send_point(-32768, 0, -32768, 1);
        random_points(60);
        drain_block();
        configure(32767, 32767, 32767, 255);
        send_point(32767, 32767, 32767, 0);
        send_point(-32768, -32768, -32768, 1);
        random_points(60);
        drain_block();

        // Sender sparse, receiver busy.
        configure(1331, 2048, 1882, 13);
        send_idle_pct = 17; recv_idle_pct = 59;
        random_points(400);
        drain_block();

        // Long receiver hold while the sender keeps offering items.
        configure(800, 3000, 500, 128);
        send_idle_pct = 0; recv_idle_pct = 0;
        hold_receiver = 1;
        fork
            random_points(80);
            begin
                repeat (300) @(posedge i_clk);
                hold_receiver = 0;
            end
        join
        drain_block();

        // Roles swapped.
        configure($urandom_range(32767), $urandom_range(32767),
                  $urandom_range(32767), $urandom_range(255));
        send_idle_pct = 59; recv_idle_pct = 17;
        random_points(300);
        drain_block();

        // Neither side idles.
        configure(1000, 2500, 1200, 40);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_points(380);
        drain_block();

        $display("Sent %0d items and checked %0d results over seven register settings,",
                 items_sent, result_count);
        $display("with idle, stall and back-pressure phases on both channels.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
